@@ sv/hbd_pkg.sv @@
// Shared types, constants and helper functions of the HTTP body deframer.
package hbd_pkg;

  localparam int CHUNK_SIZE_BITS     = 32;
  localparam int LENGTH_BITS         = 48;
  localparam int CONTENT_LENGTH_BITS = 48;
  localparam int APB_DATA_BITS       = 64;
  localparam int APB_ADDR_BITS       = 4;

  localparam logic [1:0] OP_DATA  = 2'd0;
  localparam logic [1:0] OP_CLOSE = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;

  localparam logic [1:0] MODE_NONE      = 2'd0;
  localparam logic [1:0] MODE_LENGTH    = 2'd1;
  localparam logic [1:0] MODE_CHUNKED   = 2'd2;
  localparam logic [1:0] MODE_UNTIL_END = 2'd3;

  localparam logic REG_BODY_MODE      = 1'b0;
  localparam logic REG_CONTENT_LENGTH = 1'b1;

  localparam logic [2:0] PH_DONE       = 3'd0;
  localparam logic [2:0] PH_LENGTH     = 3'd1;
  localparam logic [2:0] PH_UNTIL_END  = 3'd2;
  localparam logic [2:0] PH_SIZE_START = 3'd3;
  localparam logic [2:0] PH_SIZE_LINE  = 3'd4;
  localparam logic [2:0] PH_DATA       = 3'd5;
  localparam logic [2:0] PH_SKIP       = 3'd6;
  localparam logic [2:0] PH_TRAILER    = 3'd7;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  typedef logic [CHUNK_SIZE_BITS-1:0] chunk_t;
  typedef logic [LENGTH_BITS-1:0]     length_t;

  localparam chunk_t CHUNK_MAX       = {CHUNK_SIZE_BITS{1'b1}};
  localparam chunk_t CHUNK_SAT_LIMIT = CHUNK_MAX >> 4;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [7:0] b);
    hex_digit_t d;
    d.valid = 1'b1;
    d.value = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      d.value = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      d.value = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      d.value = 4'(b - 8'h37);
    end else begin
      d.valid = 1'b0;
    end
    return d;
  endfunction

endpackage

@@ sv/hbd_in_if.sv @@
// Input channel of the HTTP body deframer: one stream byte or command per transfer.
interface hbd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] data_byte;

  modport source (output valid, op, data_byte, input ready);
  modport sink (input valid, op, data_byte, output ready);
endinterface

@@ sv/hbd_out_if.sv @@
// Result channel of the HTTP body deframer: one status word per transfer.
interface hbd_out_if;
  logic       valid;
  logic       ready;
  logic       payload_valid;
  logic [7:0] payload_byte;
  logic       body_complete;
  logic       framing_error;
  logic       spare_byte;

  modport source (output valid, payload_valid, payload_byte, body_complete, framing_error,
                  spare_byte, input ready);
  modport sink (input valid, payload_valid, payload_byte, body_complete, framing_error,
                spare_byte, output ready);
endinterface

@@ sv/http_body_deframer.sv @@
// HTTP/1.1 body deframer with chunked transfer decoding.
//
// The item channel carries one byte or command per transfer: op 0 is a stream
// byte, op 1 reports that the connection closed and op 2 starts a new body in
// the mode held in the frame_mode register. Every item gives exactly one result
// transfer, which marks the byte as payload or spare and reports the done and
// framing error levels after the item.
// Registers are to be written over the APB port only while the block is idle,
// which the block itself does not enforce: frame_mode at byte address 0 and
// content_length at byte address 8. The result is valid in the cycle after the
// item transfer. One item is taken every cycle while results are taken; the
// phase register and the length and chunk counters update at each transfer.
// Reset leaves the block in the done state, so bytes before the first start
// are flagged as spare. The result sits in an output register; when the
// receiver stalls, the block still takes an item in the cycle in which the
// waiting result is taken, and holds off new items only while it stays.
module http_body_deframer
  import hbd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  hbd_in_if.sink                   item,
  hbd_out_if.source                result,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  logic [1:0]                     frame_mode;
  logic [CONTENT_LENGTH_BITS-1:0] content_length;

  logic [2:0] phase, phase_next;
  chunk_t     chunk_remaining, chunk_remaining_next;
  length_t    length_remaining, length_remaining_next;
  logic [1:0] skip_count, skip_count_next;
  logic       in_size_digits, in_size_digits_next;
  logic [2:0] trailer_match, trailer_match_next;
  logic [1:0] trailer_position, trailer_position_next;
  logic       error_flag, error_flag_next;

  logic       res_valid;
  logic       res_payload_valid;
  logic [7:0] res_payload_byte;
  logic       res_body_complete;
  logic       res_framing_error;
  logic       res_spare_byte;

  logic       pv, spare, accept, cfg_write;
  hex_digit_t hex;
  chunk_t     chunk_dec;
  length_t    length_dec;
  logic [7:0] trailer_want;
  logic [1:0] skip_dec;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;

  always_comb begin
    unique case (paddr[3])
      REG_BODY_MODE:      prdata = APB_DATA_BITS'(frame_mode);
      REG_CONTENT_LENGTH: prdata = APB_DATA_BITS'(content_length);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_mode     <= MODE_NONE;
      content_length <= '0;
    end else if (cfg_write) begin
      unique case (paddr[3])
        REG_BODY_MODE:      frame_mode <= pwdata[1:0];
        REG_CONTENT_LENGTH: content_length <= pwdata[CONTENT_LENGTH_BITS-1:0];
        default:            ;
      endcase
    end
  end

  assign item.ready = ~res_valid | result.ready;
  assign accept     = item.valid & item.ready;

  assign hex          = hex_decode(item.data_byte);
  assign chunk_dec    = chunk_remaining - chunk_t'(1);
  assign length_dec   = length_remaining - length_t'(1);
  assign skip_dec     = (skip_count != 2'd0) ? skip_count - 2'd1 : 2'd0;
  assign trailer_want = trailer_match[0] ? CH_LF : CH_CR;

  always_comb begin
    phase_next            = phase;
    chunk_remaining_next  = chunk_remaining;
    length_remaining_next = length_remaining;
    skip_count_next       = skip_count;
    in_size_digits_next   = in_size_digits;
    trailer_match_next    = trailer_match;
    trailer_position_next = trailer_position;
    error_flag_next       = error_flag;
    pv                    = 1'b0;
    spare                 = 1'b0;

    unique case (item.op)
      OP_START: begin
        error_flag_next       = 1'b0;
        chunk_remaining_next  = '0;
        length_remaining_next = '0;
        skip_count_next       = 2'd0;
        in_size_digits_next   = 1'b0;
        trailer_match_next    = 3'd0;
        trailer_position_next = 2'd0;
        unique case (frame_mode)
          MODE_LENGTH: begin
            length_remaining_next = LENGTH_BITS'(content_length);
            phase_next = (LENGTH_BITS'(content_length) == '0) ? PH_DONE : PH_LENGTH;
          end
          MODE_CHUNKED:   phase_next = PH_SIZE_START;
          MODE_UNTIL_END: phase_next = PH_UNTIL_END;
          default:        phase_next = PH_DONE;
        endcase
      end
      OP_CLOSE: begin
        if (!error_flag && phase != PH_DONE) begin
          if (phase != PH_UNTIL_END) begin
            error_flag_next = 1'b1;
          end
          phase_next = PH_DONE;
        end
      end
      OP_DATA: begin
        if (!error_flag) begin
          unique case (phase)
            PH_DONE: spare = 1'b1;
            PH_LENGTH: begin
              pv = 1'b1;
              length_remaining_next = length_dec;
              if (length_dec == '0) begin
                phase_next = PH_DONE;
              end
            end
            PH_UNTIL_END: pv = 1'b1;
            PH_SIZE_START: begin
              if (!hex.valid) begin
                error_flag_next = 1'b1;
                phase_next      = PH_DONE;
              end else begin
                chunk_remaining_next = chunk_t'(hex.value);
                in_size_digits_next  = 1'b1;
                phase_next           = PH_SIZE_LINE;
              end
            end
            PH_SIZE_LINE: begin
              if (item.data_byte == CH_LF) begin
                in_size_digits_next = 1'b0;
                if (chunk_remaining == '0) begin
                  trailer_match_next    = 3'd0;
                  trailer_position_next = 2'd0;
                  phase_next            = PH_TRAILER;
                end else begin
                  phase_next = PH_DATA;
                end
              end else if (!(in_size_digits && hex.valid)) begin
                in_size_digits_next = 1'b0;
              end else if (chunk_remaining > CHUNK_SAT_LIMIT) begin
                chunk_remaining_next = CHUNK_MAX;
              end else begin
                chunk_remaining_next = {chunk_remaining[CHUNK_SIZE_BITS-5:0], hex.value};
              end
            end
            PH_DATA: begin
              pv = 1'b1;
              chunk_remaining_next = chunk_dec;
              if (chunk_dec == '0) begin
                skip_count_next = 2'd2;
                phase_next      = PH_SKIP;
              end
            end
            PH_SKIP: begin
              skip_count_next = skip_dec;
              if (skip_dec == 2'd0) begin
                phase_next = PH_SIZE_START;
              end
            end
            PH_TRAILER: begin
              if (item.data_byte == trailer_want) begin
                trailer_match_next = trailer_match + 3'd1;
              end else begin
                trailer_match_next = (item.data_byte == CH_CR) ? 3'd1 : 3'd0;
              end
              if (trailer_position != 2'd2) begin
                trailer_position_next = trailer_position + 2'd1;
              end
              if ((trailer_position == 2'd1 && trailer_match_next == 3'd2) ||
                  trailer_match_next >= 3'd4) begin
                phase_next = PH_DONE;
              end
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_DONE;
      chunk_remaining  <= '0;
      length_remaining <= '0;
      skip_count       <= 2'd0;
      in_size_digits   <= 1'b0;
      trailer_match    <= 3'd0;
      trailer_position <= 2'd0;
      error_flag       <= 1'b0;
      res_valid        <= 1'b0;
    end else begin
      if (accept) begin
        phase            <= phase_next;
        chunk_remaining  <= chunk_remaining_next;
        length_remaining <= length_remaining_next;
        skip_count       <= skip_count_next;
        in_size_digits   <= in_size_digits_next;
        trailer_match    <= trailer_match_next;
        trailer_position <= trailer_position_next;
        error_flag       <= error_flag_next;
        res_valid        <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_payload_valid <= pv;
      res_payload_byte  <= pv ? item.data_byte : 8'd0;
      res_body_complete <= (phase_next == PH_DONE) && !error_flag_next;
      res_framing_error <= error_flag_next;
      res_spare_byte    <= spare;
    end
  end

  assign result.valid         = res_valid;
  assign result.payload_valid = res_payload_valid;
  assign result.payload_byte  = res_payload_byte;
  assign result.body_complete = res_body_complete;
  assign result.framing_error = res_framing_error;
  assign result.spare_byte    = res_spare_byte;

`ifndef ASSERT_OFF
  a_error_parks_done: assert property (@(posedge clk) disable iff (rst)
    error_flag |-> phase == PH_DONE)
    else $error("Framing error is set outside the done phase.");

  a_data_count_live: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> chunk_remaining != '0)
    else $error("Chunk data phase entered with an empty chunk count.");

  a_length_count_live: assert property (@(posedge clk) disable iff (rst)
    phase == PH_LENGTH |-> length_remaining != '0)
    else $error("Fixed length phase entered with an empty length count.");

  a_skip_count_live: assert property (@(posedge clk) disable iff (rst)
    phase == PH_SKIP |-> skip_count != 2'd0)
    else $error("Skip phase entered with nothing left to skip.");

  a_result_flags: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res_payload_valid && (res_spare_byte || res_framing_error)))
    else $error("Payload byte flagged together with spare or error.");
`endif

endmodule
